// ===== sv/tgrc_pkg.sv =====
// Shared types and constants for the tile grid rectangle collision unit.
// Holds item structs, controller command/status structs and the FSM state type.
// No dependencies.
`default_nettype none

package tgrc_pkg;

  // Grid geometry
  localparam int MAX_ROWS       = 16;
  localparam int MAX_COLS       = 16;
  localparam int TILE_SIZE_LOG2 = 6;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 5'd10;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 5'd15;

  typedef struct packed {
    logic               command;
    logic [3:0]         tile_row;
    logic [3:0]         tile_col;
    logic signed [15:0] tile_value;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [11:0]        rect_w;
    logic [11:0]        rect_h;
    logic signed [15:0] scroll_offset;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic was_query;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic do_write;
    logic do_geom;
    logic do_bound;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic bound_empty;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BOUND,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== sv/tgrc_ctrl.sv =====
// Sequencer for the tile grid rectangle collision unit.
// Issues datapath commands per item; uses tgrc_pkg.
`default_nettype none

module tgrc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tgrc_pkg::dp_status_t status_i,
  output tgrc_pkg::ctrl_cmd_t      cmd_o
);
  import tgrc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_query) begin
          cmd_o.do_geom = 1'b1;
          state_d       = ST_BOUND;
        end else begin
          cmd_o.do_write = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_BOUND: begin
        cmd_o.do_bound = 1'b1;
        state_d        = status_i.bound_empty ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read lands in the accumulator this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A captured item always leaves idle and only a result load returns there.
  a_capture_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_DECODE)
    else $error("capture did not advance to decode");

  a_idle_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_d == ST_IDLE) |-> cmd_o.load_out)
    else $error("returned to idle without loading a result");

  a_scan_then_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_step && status_i.scan_last) |=> state_q == ST_DRAIN)
    else $error("scan end not followed by drain");

endmodule

`default_nettype wire

// ===== sv/tgrc_datapath.sv =====
// Datapath of the tile grid rectangle collision unit: item register, config
// registers, bound math, scan counters, solid-flag memory and output register.
// Uses tgrc_pkg.
`default_nettype none

module tgrc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tgrc_pkg::in_item_t           in_data_i,
  output tgrc_pkg::out_item_t               out_data_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [tgrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tgrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire tgrc_pkg::ctrl_cmd_t          cmd_i,
  output tgrc_pkg::dp_status_t              status_o
);
  import tgrc_pkg::*;

  localparam logic signed [17:0] TILE_BIAS = 18'((1 << TILE_SIZE_LOG2) - 1);
  localparam logic [6:0] MAX_ROWS_7 = 7'(MAX_ROWS);
  localparam logic [6:0] MAX_COLS_7 = 7'(MAX_COLS);

  // division by tile size, truncating toward zero
  function automatic logic signed [17:0] trunc_div(input logic signed [17:0] v);
    logic signed [17:0] biased;
    biased = v[17] ? (v + TILE_BIAS) : v;
    return biased >>> TILE_SIZE_LOG2;
  endfunction

  function automatic logic [ADDR_W-1:0] tile_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // ---------------- config registers
  logic [CFG_DATA_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS_IN_USE: rows_q <= cfg_data_i;
        REG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- item register
  in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // ---------------- edge sums
  logic signed [17:0] x_rel_q, x_end_q, y_top_q, y_end_q;
  logic signed [17:0] x_ext, y_ext, s_ext, w_ext, h_ext;

  assign x_ext = $signed({{2{item_q.rect_x[15]}}, item_q.rect_x});
  assign y_ext = $signed({{2{item_q.rect_y[15]}}, item_q.rect_y});
  assign s_ext = $signed({{2{item_q.scroll_offset[15]}}, item_q.scroll_offset});
  assign w_ext = $signed({6'b0, item_q.rect_w});
  assign h_ext = $signed({6'b0, item_q.rect_h});

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_geom) begin
      x_rel_q <= x_ext - s_ext;
      x_end_q <= x_ext + w_ext - s_ext;
      y_top_q <= y_ext;
      y_end_q <= y_ext + h_ext;
    end
  end

  // ---------------- clamped bounds
  logic [6:0]         rows_eff, cols_eff;
  logic signed [17:0] rows_m1, cols_m1;
  logic signed [17:0] left, right, top, bottom;
  logic signed [17:0] left_c, right_c, top_c, bottom_c;
  logic               empty;

  always_comb begin
    rows_eff = ({2'b0, rows_q} > MAX_ROWS_7) ? MAX_ROWS_7 : {2'b0, rows_q};
    cols_eff = ({2'b0, cols_q} > MAX_COLS_7) ? MAX_COLS_7 : {2'b0, cols_q};
    rows_m1  = $signed({11'b0, rows_eff}) - 18'sd1;
    cols_m1  = $signed({11'b0, cols_eff}) - 18'sd1;
    left     = trunc_div(x_rel_q);
    right    = trunc_div(x_end_q);
    top      = trunc_div(y_top_q);
    bottom   = trunc_div(y_end_q);
    left_c   = left[17] ? 18'sd0 : left;
    top_c    = top[17]  ? 18'sd0 : top;
    right_c  = (right  > cols_m1) ? cols_m1 : right;
    bottom_c = (bottom > rows_m1) ? rows_m1 : bottom;
    empty    = (left_c > right_c) || (top_c > bottom_c);
  end

  // ---------------- scan counters
  logic [COL_W-1:0] left_q, right_q, col_q;
  logic [ROW_W-1:0] bottom_q, row_q;
  logic             empty_q;
  logic             scan_last;

  assign scan_last = (col_q == right_q) && (row_q == bottom_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_bound) begin
      left_q   <= left_c[COL_W-1:0];
      right_q  <= right_c[COL_W-1:0];
      bottom_q <= bottom_c[ROW_W-1:0];
      col_q    <= left_c[COL_W-1:0];
      row_q    <= top_c[ROW_W-1:0];
      empty_q  <= empty;
    end else if (cmd_i.scan_step && !scan_last) begin
      if (col_q == right_q) begin
        col_q <= left_q;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // ---------------- solid-flag store
  logic             mem [DEPTH];
  logic [DEPTH-1:0] written_q;
  logic [6:0]       wr_row_ext, wr_col_ext;
  logic             wr_in_range;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic             wr_solid;

  assign wr_row_ext  = {3'b0, item_q.tile_row};
  assign wr_col_ext  = {3'b0, item_q.tile_col};
  assign wr_in_range = (wr_row_ext < MAX_ROWS_7) && (wr_col_ext < MAX_COLS_7);
  assign wr_addr     = tile_addr(wr_row_ext[ROW_W-1:0], wr_col_ext[COL_W-1:0]);
  assign rd_addr     = tile_addr(row_q, col_q);
  assign wr_solid    = !item_q.tile_value[15] && (item_q.tile_value != 16'sd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && wr_in_range) begin
      mem[wr_addr] <= wr_solid;
    end
  end

  // entries never written read as clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (cmd_i.do_write && wr_in_range) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  logic rd_data_q, rd_written_q, rd_pend_q, hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rd_data_q    <= mem[rd_addr];
      rd_written_q <= written_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        hit_q <= 1'b0;
      end else if (rd_pend_q && rd_data_q && rd_written_q) begin
        hit_q <= 1'b1;
      end
    end
  end

  // ---------------- output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.hit       <= hit_q && (item_q.command == CMD_QUERY);
      out_q.was_query <= (item_q.command == CMD_QUERY);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_query    = (item_q.command == CMD_QUERY);
  assign status_o.bound_empty = empty;
  assign status_o.scan_last   = scan_last;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // ---------------- checks
  a_no_scan_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !empty_q)
    else $error("scan issued on an empty range");

  a_write_ack_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.was_query) |-> !out_q.hit)
    else $error("write acknowledge carries a hit");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ===== sv/tile_grid_rect_collision_unit.sv =====
// Top level of the tile grid rectangle collision unit.
// Joins tgrc_ctrl and tgrc_datapath; uses tgrc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
//   transfer: command 0 writes one tile's solid flag (tile_value > 0), command
//   1 queries a rectangle against the grid in use. Every item produces exactly
//   one result transfer on the output channel (out_valid_o / out_stall_i /
//   out_data_o): hit and was_query.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) sets rows_in_use and
//   cols_in_use; write only while the block is idle.
//   Timing: one item in flight. A write passes through decode and finish;
//   a query passes through decode, bound, a scan over every tile of the
//   clamped range, drain and finish, and an empty range goes from bound
//   straight to finish. The scan reads one flag per cycle from the single
//   read port of the tile store, so the range size sets the scan length.
//   Reset: rows_in_use = 10, cols_in_use = 15, all tiles clear (per-entry
//   written bits are cleared at once, so no clearing pass is needed).
//   Stall: a result waits in the output register; the next input is still
//   taken, and its result is held back until the waiting one is transferred.
`default_nettype none

module tile_grid_rect_collision_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire tgrc_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output tgrc_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tgrc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tgrc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tgrc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: decode, bound, scan, drain, finish
  tgrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tile store, bound math and output register
  tgrc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire
